// ===== design/cutc_pkg.sv =====
`default_nettype none

package cutc_pkg;

	localparam int NSTG = 6;

	localparam int EPOCH_YEAR = 1970;
	localparam int LAST_YEAR = 2105;
	localparam int CENTURY_NONLEAP = 2100;
	// first year offset whose leap count loses the skipped century year
	localparam int CENTURY_YO = CENTURY_NONLEAP - EPOCH_YEAR + 1;

	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;
	localparam logic [31:0] LAST_EPOCH_SECOND = 32'd4291747199;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

	// reciprocals for exact constant division over the value ranges in use
	localparam logic [25:0] DAY_RECIP = 26'd50903317;	// (x >> 7) / 675
	localparam int DAY_SHIFT = 35;
	localparam logic [15:0] YEAR_RECIP = 16'd45965;		// days / 365
	localparam int YEAR_SHIFT = 24;
	localparam logic [17:0] HOUR_RECIP = 18'd149131;	// sod / 3600
	localparam int HOUR_SHIFT = 29;
	localparam logic [12:0] MIN_RECIP = 13'd4370;		// rem / 60
	localparam int MIN_SHIFT = 18;

	typedef enum logic {
		CMD_D2S = 1'b0,
		CMD_S2D = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [31:0] epoch_seconds;
	} req_t;

	typedef struct packed {
		logic [31:0] out_epoch_seconds;
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [5:0]  out_second;
		logic        range_error;
	} rsp_t;

	typedef struct packed {
		logic [NSTG-1:0] load;
	} pipe_ctl_t;

	// exact Gregorian rule for the supported span 1970..2105
	function automatic logic leap_in_span(logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != 12'(CENTURY_NONLEAP));
	endfunction

	function automatic logic [15:0] days_before_year(logic [7:0] yo);
		logic [16:0] base;
		logic [8:0]  yp;
		logic [6:0]  leaps;
		base = 17'(yo) * 17'(DAYS_PER_YEAR);
		yp = {1'b0, yo} + 9'd1;
		leaps = 7'(yp >> 2) - ((yo >= 8'(CENTURY_YO)) ? 7'd1 : 7'd0);
		return 16'(base + 17'(leaps));
	endfunction

	function automatic logic [8:0] days_before_month(logic [3:0] m, logic leap);
		logic [8:0] d;
		case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		if (leap && m >= 4'd3 && m <= 4'd12)
			d = d + 9'd1;
		return d;
	endfunction

	function automatic logic [4:0] month_length(logic [3:0] m, logic leap);
		logic [4:0] n;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2:                    n = leap ? 5'd29 : 5'd28;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== design/cutc_if.sv =====
`default_nettype none

interface cutc_req_if;
	logic            valid;
	logic            ready;
	cutc_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cutc_rsp_if;
	logic            valid;
	logic            ready;
	cutc_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cutc_ctrl.sv =====
`default_nettype none

module cutc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cutc_pkg::pipe_ctl_t      ctl
);

	logic [cutc_pkg::NSTG-1:0] vld_q;
	logic [cutc_pkg::NSTG:0]   rdy;

	// a stage takes new data when it is empty or its content moves on
	always_comb begin
		rdy[cutc_pkg::NSTG] = out_ready;
		for (int k = cutc_pkg::NSTG - 1; k >= 0; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < cutc_pkg::NSTG; k++)
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign ctl.load  = rdy[cutc_pkg::NSTG-1:0];
	assign in_ready  = rdy[0];
	assign out_valid = vld_q[cutc_pkg::NSTG-1];

endmodule

`default_nettype wire

// ===== design/cutc_d2s.sv =====
`default_nettype none

module cutc_d2s (
	input  wire logic                 clk,
	input  wire cutc_pkg::pipe_ctl_t  ctl,
	input  wire cutc_pkg::req_t       req,
	output logic [31:0]               eps,
	output logic                      err
);

	logic        act_s1, err_s1;
	logic [7:0]  yo_s1;
	logic [8:0]  dom_s1;
	logic [16:0] sod_s1;

	logic        act_s2, err_s2;
	logic [15:0] days_s2;
	logic [16:0] sod_s2;

	logic [31:0] eps_s3, eps_s4, eps_s5;
	logic        err_s3, err_s4, err_s5;

	logic        leap;
	logic        ok;
	logic [16:0] sod;
	logic [32:0] total;

	always_comb begin
		leap = cutc_pkg::leap_in_span(req.year);
		ok = (req.year >= 12'(cutc_pkg::EPOCH_YEAR)) && (req.year <= 12'(cutc_pkg::LAST_YEAR))
			&& (req.month >= 4'd1) && (req.month <= 4'd12)
			&& (req.day >= 5'd1) && (req.day <= cutc_pkg::month_length(req.month, leap))
			&& (req.hour <= 5'd23) && (req.minute <= 6'd59) && (req.second <= 6'd59);
		sod = 17'(req.hour) * 17'(cutc_pkg::SECS_PER_HOUR)
			+ 17'(req.minute) * 17'(cutc_pkg::SECS_PER_MIN)
			+ 17'(req.second);
		total = 33'(days_s2) * 33'(cutc_pkg::SECS_PER_DAY) + 33'(sod_s2);
	end

	always_ff @(posedge clk) begin
		// check fields, split into year offset, day of year and second of day
		if (ctl.load[0]) begin
			act_s1 <= (req.command == cutc_pkg::CMD_D2S);
			err_s1 <= !ok;
			yo_s1  <= 8'(req.year - 12'(cutc_pkg::EPOCH_YEAR));
			dom_s1 <= cutc_pkg::days_before_month(req.month, leap) + 9'(req.day) - 9'd1;
			sod_s1 <= sod;
		end
		// day count since the epoch
		if (ctl.load[1]) begin
			act_s2  <= act_s1;
			err_s2  <= err_s1;
			days_s2 <= cutc_pkg::days_before_year(yo_s1) + 16'(dom_s1);
			sod_s2  <= sod_s1;
		end
		// scale to seconds; drop the result for the other command or on error
		if (ctl.load[2]) begin
			eps_s3 <= (act_s2 && !err_s2) ? total[31:0] : 32'd0;
			err_s3 <= act_s2 && err_s2;
		end
		if (ctl.load[3]) begin
			eps_s4 <= eps_s3;
			err_s4 <= err_s3;
		end
		if (ctl.load[4]) begin
			eps_s5 <= eps_s4;
			err_s5 <= err_s4;
		end
	end

	assign eps = eps_s5;
	assign err = err_s5;

endmodule

`default_nettype wire

// ===== design/cutc_s2d.sv =====
`default_nettype none

module cutc_s2d (
	input  wire logic                 clk,
	input  wire cutc_pkg::pipe_ctl_t  ctl,
	input  wire cutc_pkg::req_t       req,
	output cutc_pkg::rsp_t            res
);

	logic        act_s1, err_s1;
	logic [15:0] days_s1;
	logic [31:0] esec_s1;

	logic        act_s2, err_s2;
	logic [15:0] days_s2;
	logic [16:0] sod_s2;
	logic [7:0]  guess_s2;

	logic        act_s3, err_s3;
	logic [7:0]  yo_s3;
	logic [8:0]  doy_s3;
	logic [4:0]  hour_s3;
	logic [16:0] sod_s3;

	logic        act_s4, err_s4;
	logic [11:0] year_s4;
	logic [3:0]  month_s4;
	logic [4:0]  day_s4;
	logic [4:0]  hour_s4;
	logic [11:0] remh_s4;

	logic        act_s5, err_s5;
	logic [11:0] year_s5;
	logic [3:0]  month_s5;
	logic [4:0]  day_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  minute_s5;
	logic [11:0] remh_s5;

	logic [50:0] day_prod;
	logic [32:0] day_secs;
	logic [31:0] year_prod;
	logic [15:0] dby_g, dby_p;
	logic        over;
	logic [34:0] hour_prod;
	logic [11:0] year4;
	logic        leap4;
	logic [3:0]  mon4;
	logic [24:0] min_prod;
	logic [11:0] min_secs;
	logic [5:0]  second5;
	logic        keep;

	always_comb begin
		day_prod  = 51'(req.epoch_seconds[31:7]) * 51'(cutc_pkg::DAY_RECIP);
		day_secs  = 33'(days_s1) * 33'(cutc_pkg::SECS_PER_DAY);
		year_prod = 32'(days_s1) * 32'(cutc_pkg::YEAR_RECIP);
		dby_g     = cutc_pkg::days_before_year(guess_s2);
		dby_p     = cutc_pkg::days_before_year(guess_s2 - 8'd1);
		over      = dby_g > days_s2;
		hour_prod = 35'(sod_s2) * 35'(cutc_pkg::HOUR_RECIP);
		year4     = 12'(cutc_pkg::EPOCH_YEAR) + 12'(yo_s3);
		leap4     = cutc_pkg::leap_in_span(year4);
		mon4      = 4'd1;
		for (int k = 2; k <= 12; k++)
			if (doy_s3 >= cutc_pkg::days_before_month(4'(k), leap4))
				mon4 = 4'(k);
		min_prod  = 25'(remh_s4) * 25'(cutc_pkg::MIN_RECIP);
		min_secs  = 12'(minute_s5) * 12'(cutc_pkg::SECS_PER_MIN);
		second5   = 6'(remh_s5 - min_secs);
	end

	always_ff @(posedge clk) begin
		// whole days by reciprocal multiply
		if (ctl.load[0]) begin
			act_s1  <= (req.command == cutc_pkg::CMD_S2D);
			err_s1  <= req.epoch_seconds > cutc_pkg::LAST_EPOCH_SECOND;
			days_s1 <= day_prod[cutc_pkg::DAY_SHIFT+15:cutc_pkg::DAY_SHIFT];
			esec_s1 <= req.epoch_seconds;
		end
		// second of day, first year estimate
		if (ctl.load[1]) begin
			act_s2   <= act_s1;
			err_s2   <= err_s1;
			days_s2  <= days_s1;
			sod_s2   <= 17'(33'(esec_s1) - day_secs);
			guess_s2 <= year_prod[cutc_pkg::YEAR_SHIFT+7:cutc_pkg::YEAR_SHIFT];
		end
		// correct the year estimate down by one when it overshoots
		if (ctl.load[2]) begin
			act_s3  <= act_s2;
			err_s3  <= err_s2;
			yo_s3   <= over ? guess_s2 - 8'd1 : guess_s2;
			doy_s3  <= 9'(days_s2 - (over ? dby_p : dby_g));
			hour_s3 <= hour_prod[cutc_pkg::HOUR_SHIFT+4:cutc_pkg::HOUR_SHIFT];
			sod_s3  <= sod_s2;
		end
		// month and day, seconds left in the hour
		if (ctl.load[3]) begin
			act_s4   <= act_s3;
			err_s4   <= err_s3;
			year_s4  <= year4;
			month_s4 <= mon4;
			day_s4   <= 5'(doy_s3 - cutc_pkg::days_before_month(mon4, leap4) + 9'd1);
			hour_s4  <= hour_s3;
			remh_s4  <= 12'(sod_s3 - 17'(hour_s3) * 17'(cutc_pkg::SECS_PER_HOUR));
		end
		if (ctl.load[4]) begin
			act_s5    <= act_s4;
			err_s5    <= err_s4;
			year_s5   <= year_s4;
			month_s5  <= month_s4;
			day_s5    <= day_s4;
			hour_s5   <= hour_s4;
			minute_s5 <= min_prod[cutc_pkg::MIN_SHIFT+5:cutc_pkg::MIN_SHIFT];
			remh_s5   <= remh_s4;
		end
	end

	always_comb begin
		keep = act_s5 && !err_s5;
		res.out_epoch_seconds = 32'd0;
		res.out_year   = keep ? year_s5 : 12'd0;
		res.out_month  = keep ? month_s5 : 4'd0;
		res.out_day    = keep ? day_s5 : 5'd0;
		res.out_hour   = keep ? hour_s5 : 5'd0;
		res.out_minute = keep ? minute_s5 : 6'd0;
		res.out_second = keep ? second5 : 6'd0;
		res.range_error = act_s5 && err_s5;
	end

endmodule

`default_nettype wire

// ===== design/calendar_unix_time_converter.sv =====
// Channel  Modport  Direction  Carries
// -------  -------  ---------  -----------------------------------------------
// req      sink     in         command, date-time fields, epoch_seconds
// rsp      source   out        epoch seconds or date-time fields, range_error
//
// One request per cycle sustained while rsp is ready; every request gives
// one response through the six-stage pipeline (reciprocal multiplies for
// the day, year, hour and minute splits, one per stage).
// arst_n clears the stage valid bits only; the datapath registers have no reset.
// A stage advances when it is empty or its content moves on, so a stall at
// rsp backs up stage by stage and nothing is dropped or repeated.
`default_nettype none

module calendar_unix_time_converter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cutc_req_if.sink   req,
	cutc_rsp_if.source rsp
);

	cutc_pkg::pipe_ctl_t ctl;
	cutc_pkg::rsp_t      s2d_res;
	cutc_pkg::rsp_t      rsp_mux;
	cutc_pkg::rsp_t      rsp_s6;
	logic [31:0]         d2s_eps;
	logic                d2s_err;

	// handshake and stage valid bits
	cutc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	// date-time to seconds: closed-form day count, then scale
	cutc_d2s u_d2s (
		.clk (clk),
		.ctl (ctl),
		.req (req.data),
		.eps (d2s_eps),
		.err (d2s_err)
	);

	// seconds to date-time: split days, years, months and time of day
	cutc_s2d u_s2d (
		.clk (clk),
		.ctl (ctl),
		.req (req.data),
		.res (s2d_res)
	);

	// merge both directions; the unused one is already zero
	always_comb begin
		rsp_mux = s2d_res;
		rsp_mux.out_epoch_seconds = d2s_eps;
		rsp_mux.range_error = s2d_res.range_error | d2s_err;
	end

	// output stage
	always_ff @(posedge clk) begin
		if (ctl.load[cutc_pkg::NSTG-1]) begin
			rsp_s6 <= rsp_mux;
		end
	end

	assign rsp.data = rsp_s6;

	// an empty output stage means every stage can take data
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request refused while pipeline is empty");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.range_error |->
			rsp.data.out_epoch_seconds == 32'd0 && rsp.data.out_year == 12'd0
			&& rsp.data.out_month == 4'd0 && rsp.data.out_second == 6'd0)
		else $error("error response carries nonzero fields");

	a_month_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.out_year != 12'd0 |->
			rsp.data.out_month >= 4'd1 && rsp.data.out_month <= 4'd12
			&& rsp.data.out_day >= 5'd1 && rsp.data.out_hour <= 5'd23)
		else $error("date response out of calendar range");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.out_year != 12'd0 |->
			rsp.data.out_epoch_seconds == 32'd0 && !rsp.data.range_error)
		else $error("both directions present in one response");

endmodule

`default_nettype wire

// ===== sim/calendar_unix_time_checker.sv =====
`timescale 1ns / 1ps

module calendar_unix_time_checker
	import cutc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  req_t      req_data,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  rsp_t      rsp_data,
	output int        mismatches,
	output int        outstanding
);

	rsp_t pending_results[$];

	function automatic bit is_leap(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		if (m == 2)
			return is_leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic int unsigned days_in_year(int unsigned y);
		return is_leap(y) ? 366 : 365;
	endfunction

	// Expected conversion of one request, in either direction.
	function automatic rsp_t convert_request(req_t r);
		rsp_t        res;
		logic [63:0] total;
		int unsigned y;
		int unsigned m;
		int unsigned rest;
		res = '0;
		if (r.command == CMD_D2S) begin
			if (r.year < EPOCH_YEAR || r.year > LAST_YEAR || r.month < 1 || r.month > 12 ||
			    r.day < 1 || r.day > days_in_month(r.month, r.year) ||
			    r.hour > 23 || r.minute > 59 || r.second > 59) begin
				res.range_error = 1'b1;
				return res;
			end
			total = '0;
			for (y = EPOCH_YEAR; y < r.year; y++)
				total += 64'(days_in_year(y)) * SECS_PER_DAY;
			for (m = 1; m < r.month; m++)
				total += 64'(days_in_month(m, r.year)) * SECS_PER_DAY;
			total += 64'(r.day - 1) * SECS_PER_DAY;
			total += 64'(r.hour) * SECS_PER_HOUR + 64'(r.minute) * SECS_PER_MIN + 64'(r.second);
			res.out_epoch_seconds = total[31:0];
		end else begin
			if (r.epoch_seconds > LAST_EPOCH_SECOND) begin
				res.range_error = 1'b1;
				return res;
			end
			rest = r.epoch_seconds;
			y = EPOCH_YEAR;
			m = 1;
			while (y < LAST_YEAR && rest >= days_in_year(y) * SECS_PER_DAY) begin
				rest -= days_in_year(y) * SECS_PER_DAY;
				y++;
			end
			while (m < 12 && rest >= days_in_month(m, y) * SECS_PER_DAY) begin
				rest -= days_in_month(m, y) * SECS_PER_DAY;
				m++;
			end
			res.out_year = 12'(y);
			res.out_month = 4'(m);
			res.out_day = 5'(1 + rest / SECS_PER_DAY);
			rest = rest % SECS_PER_DAY;
			res.out_hour = 5'(rest / SECS_PER_HOUR);
			rest = rest % SECS_PER_HOUR;
			res.out_minute = 6'(rest / SECS_PER_MIN);
			res.out_second = 6'(rest % SECS_PER_MIN);
		end
		return res;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				pending_results.push_back(convert_request(req_data));
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: response with none expected: actual %h", $time, rsp_data);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("out_epoch_seconds", want.out_epoch_seconds,
						rsp_data.out_epoch_seconds);
					check_field("out_year", want.out_year, rsp_data.out_year);
					check_field("out_month", want.out_month, rsp_data.out_month);
					check_field("out_day", want.out_day, rsp_data.out_day);
					check_field("out_hour", want.out_hour, rsp_data.out_hour);
					check_field("out_minute", want.out_minute, rsp_data.out_minute);
					check_field("out_second", want.out_second, rsp_data.out_second);
					check_field("range_error", want.range_error, rsp_data.range_error);
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== sim/calendar_unix_time_converter_test.sv =====
`timescale 1ns / 1ps

// Drive date/epoch conversion requests into the converter with random gaps,
// stall the response side at random, and let the checker predict and compare.
// The top only builds stimulus and gives the verdict.
module calendar_unix_time_converter_test;
	import cutc_pkg::*;

	localparam int RANDOM_REQUESTS = 1000;
	// pipeline is six stages deep; drain a comfortable margin past that
	localparam int DRAIN_CYCLES = 20;
	localparam int DRAIN_LIMIT = 10000;

	logic clk;
	logic arst_n;
	// no idling on either side while set
	bit   steady;
	int   mismatches;
	int   outstanding;

	cutc_req_if req ();
	cutc_rsp_if rsp ();

	calendar_unix_time_converter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	calendar_unix_time_checker CHECK (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_data    (req.data),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_data    (rsp.data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Build a date-to-seconds request; fill the unused epoch field with noise.
	function automatic req_t date_request(logic [11:0] y, logic [3:0] mo, logic [4:0] d,
			logic [4:0] h, logic [5:0] mi, logic [5:0] s);
		req_t r;
		r.command = CMD_D2S;
		r.year = y;
		r.month = mo;
		r.day = d;
		r.hour = h;
		r.minute = mi;
		r.second = s;
		r.epoch_seconds = $urandom;
		return r;
	endfunction

	// Build a seconds-to-date request; fill the unused date fields with noise.
	function automatic req_t seconds_request(logic [31:0] e);
		req_t r;
		r.command = CMD_S2D;
		r.year = 12'($urandom);
		r.month = 4'($urandom);
		r.day = 5'($urandom);
		r.hour = 5'($urandom);
		r.minute = 6'($urandom);
		r.second = 6'($urandom);
		r.epoch_seconds = e;
		return r;
	endfunction

	// Hold valid low for a random gap, then present the request and hold it
	// until the converter takes it. Valid stays high when the next gap is zero.
	task automatic send_request(req_t item);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= item;
		do @(posedge clk); while (!req.ready);
	endtask

	// Response side: draw a stall per response, then take it.
	initial begin
		int stall;
		rsp.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin
		int pick;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		steady = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: calendar extremes, leap rules, every bad field, range edges.
		send_request(date_request(12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
		send_request(date_request(12'd2105, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
		send_request(date_request(12'd2000, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30));
		send_request(date_request(12'd2100, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0));
		send_request(date_request(12'd2100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59));
		send_request(date_request(12'd1972, 4'd2, 5'd29, 5'd1, 6'd2, 6'd3));
		send_request(date_request(12'd1971, 4'd2, 5'd29, 5'd1, 6'd2, 6'd3));
		send_request(date_request(12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
		send_request(date_request(12'd2106, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
		send_request(date_request(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
		send_request(date_request(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0));
		send_request(date_request(12'd1999, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0));
		send_request(date_request(12'd1999, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0));
		send_request(date_request(12'd1999, 4'd6, 5'd30, 5'd24, 6'd0, 6'd0));
		send_request(date_request(12'd1999, 4'd9, 5'd30, 5'd0, 6'd60, 6'd0));
		send_request(date_request(12'd1999, 4'd11, 5'd30, 5'd0, 6'd0, 6'd60));
		send_request(seconds_request(32'd0));
		send_request(seconds_request(LAST_EPOCH_SECOND));
		send_request(seconds_request(LAST_EPOCH_SECOND + 32'd1));
		send_request(seconds_request(32'hFFFF_FFFF));
		send_request(seconds_request(32'd951782400));   // leap day of a 400-year
		send_request(seconds_request(32'd4107542399));  // end of Feb in a century year
		send_request(seconds_request(32'd68255999));    // last second of a leap day
		send_request(seconds_request(32'd86399));

		// Random: mostly well-formed dates and in-range seconds, the rest raw noise.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			steady = ((n / 100) % 4) == 3;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_request(date_request(12'($urandom_range(EPOCH_YEAR, LAST_YEAR)),
					4'($urandom_range(1, 12)),
					5'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 31)
						: $urandom_range(1, 28)),
					5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
					6'($urandom_range(0, 59))));
			else if (pick < 55)
				send_request(date_request(12'($urandom), 4'($urandom), 5'($urandom),
					5'($urandom), 6'($urandom), 6'($urandom)));
			else if (pick < 85)
				send_request(seconds_request($urandom_range(0, LAST_EPOCH_SECOND)));
			else if (pick < 90)
				send_request(seconds_request(LAST_EPOCH_SECOND - $urandom_range(0, 200000)));
			else if (pick < 93)
				send_request(seconds_request($urandom_range(0, 200000)));
			else
				send_request(seconds_request($urandom));
		end
		req.valid <= 1'b0;
		steady = 1'b0;

		// Drain: sample counters away from the rising edge.
		for (int w = 0; w < DRAIN_LIMIT && outstanding != 0; w++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/cutc_pkg.sv
design/cutc_if.sv
design/cutc_ctrl.sv
design/cutc_d2s.sv
design/cutc_s2d.sv
design/calendar_unix_time_converter.sv
sim/calendar_unix_time_checker.sv
sim/calendar_unix_time_converter_test.sv
